// File: design/ltwq_pkg.sv
// Package for the lock table with waiter queues.
// Holds the table sizes, the command and result codes and the decision record
// passed from the table to the result sequencer. Depends on nothing.
package ltwq_pkg;

	// Table geometry.
	localparam int NUM_LOCKS   = 16;
	localparam int QUEUE_DEPTH = 8;
	localparam int CLIENT_BITS = 8;

	localparam int LOCK_W = $clog2(NUM_LOCKS);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_LOCKS * QUEUE_DEPTH);

	// A command can produce at most this many results.
	localparam int MAX_RES = 3;
	localparam int RES_W   = $clog2(MAX_RES + 1);
	localparam int IDX_W   = $clog2(MAX_RES);

	typedef logic [LOCK_W-1:0]      lock_t;
	typedef logic [CLIENT_BITS-1:0] client_t;
	typedef logic [QPTR_W-1:0]      qptr_t;
	typedef logic [CNT_W-1:0]       qcount_t;
	typedef logic [ADDR_W-1:0]      waddr_t;

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_OK           = 3'd0,
		KIND_RETRY_REPLY  = 3'd1,
		KIND_REVOKE       = 3'd2,
		KIND_RETRY_MSG    = 3'd3,
		KIND_QUEUE_FULL   = 3'd4
	} kind_t;

	// Decision for one request: the ordered list of results it produces.
	typedef struct packed {
		logic                             valid;
		logic [RES_W-1:0]                 num;
		lock_t                            lock;
		kind_t [MAX_RES-1:0]              kind;
		logic [MAX_RES-1:0][CLIENT_BITS-1:0] who;
	} plan_t;

endpackage

// File: design/ltwq_table.sv
// Lock state, holder table, per-lock waiter FIFOs and the decision logic.
// Registers the request and the addressed lock's state, then decides and updates
// in the following cycle. Depends on ltwq_pkg.
module ltwq_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            command,
	input  logic [3:0]      lock_index,
	input  logic [7:0]      client,
	output ltwq_pkg::plan_t plan
);
	import ltwq_pkg::*;

	// Per-lock state in flip-flops, read only at the incoming lock index.
	logic [NUM_LOCKS-1:0] locked_q;
	client_t              holder_q [NUM_LOCKS];
	qptr_t                head_q   [NUM_LOCKS];
	qcount_t              count_q  [NUM_LOCKS];

	// Waiter storage: one FIFO of QUEUE_DEPTH slots per lock.
	client_t              waiter_mem [NUM_LOCKS*QUEUE_DEPTH];

	// Request and lock state captured at acceptance.
	logic    valid_s1;
	cmd_t    cmd_s1;
	lock_t   lk_s1;
	client_t who_s1;
	logic    locked_s1;
	client_t holder_s1;
	qptr_t   head_s1;
	qcount_t count_s1;
	client_t waiter_s1;

	lock_t   lk_in;
	waddr_t  rd_addr;
	waddr_t  wr_addr;
	logic [CNT_W:0] slot_sum;
	qptr_t   push_slot;
	qptr_t   head_next;
	logic    lock_set;
	logic    lock_clr;
	logic    push;
	logic    pop;

	// The index field spans exactly the table, so no reduction is needed.
	assign lk_in   = LOCK_W'(lock_index);
	assign rd_addr = ADDR_W'(ADDR_W'(lk_in) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[lk_in]));

	// The tail slot wraps round the FIFO; the sum stays below twice the depth.
	always_comb begin
		slot_sum = (CNT_W+1)'(head_s1) + (CNT_W+1)'(count_s1);
		if (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			push_slot = QPTR_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH));
		end else begin
			push_slot = QPTR_W'(slot_sum);
		end
		if (head_s1 == QPTR_W'(QUEUE_DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = head_s1 + 1'b1;
		end
		wr_addr = ADDR_W'(ADDR_W'(lk_s1) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(push_slot));
	end

	// Capture the request and the addressed lock's state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_t'(command);
			lk_s1     <= lk_in;
			who_s1    <= CLIENT_BITS'(client);
			locked_s1 <= locked_q[lk_in];
			holder_s1 <= holder_q[lk_in];
			head_s1   <= head_q[lk_in];
			count_s1  <= count_q[lk_in];
		end
	end

	// Waiter memory: front entry read at acceptance, new waiter written on decision.
	always_ff @(posedge clk) begin
		if (accept) begin
			waiter_s1 <= waiter_mem[rd_addr];
		end
		if (valid_s1 && push) begin
			waiter_mem[wr_addr] <= who_s1;
		end
	end

	// Decide the state change and the ordered results for the request.
	always_comb begin
		plan       = '0;
		plan.valid = valid_s1;
		plan.lock  = lk_s1;
		lock_set   = 1'b0;
		lock_clr   = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		if (cmd_s1 == CMD_ACQUIRE) begin
			if (!locked_s1) begin
				lock_set     = 1'b1;
				plan.num     = RES_W'(1);
				plan.kind[0] = KIND_OK;
				plan.who[0]  = who_s1;
			end else if (count_s1 >= CNT_W'(QUEUE_DEPTH)) begin
				plan.num     = RES_W'(1);
				plan.kind[0] = KIND_QUEUE_FULL;
				plan.who[0]  = who_s1;
			end else begin
				push         = 1'b1;
				plan.num     = RES_W'(2);
				plan.kind[0] = KIND_REVOKE;
				plan.who[0]  = holder_s1;
				plan.kind[1] = KIND_RETRY_REPLY;
				plan.who[1]  = who_s1;
			end
		end else begin
			lock_clr = 1'b1;
			if (count_s1 != '0) begin
				pop          = 1'b1;
				plan.kind[0] = KIND_RETRY_MSG;
				plan.who[0]  = waiter_s1;
				if (count_s1 > CNT_W'(1)) begin
					plan.num     = RES_W'(3);
					plan.kind[1] = KIND_REVOKE;
					plan.who[1]  = waiter_s1;
					plan.kind[2] = KIND_OK;
					plan.who[2]  = who_s1;
				end else begin
					plan.num     = RES_W'(2);
					plan.kind[1] = KIND_OK;
					plan.who[1]  = who_s1;
				end
			end else begin
				plan.num     = RES_W'(1);
				plan.kind[0] = KIND_OK;
				plan.who[0]  = who_s1;
			end
		end
	end

	// Write back the lock flag, holder, head and count of the addressed lock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= '0;
			for (int i = 0; i < NUM_LOCKS; i++) begin
				holder_q[i] <= '0;
				head_q[i]   <= '0;
				count_q[i]  <= '0;
			end
		end else if (valid_s1) begin
			if (lock_set) begin
				locked_q[lk_s1] <= 1'b1;
				holder_q[lk_s1] <= who_s1;
			end
			if (lock_clr) begin
				locked_q[lk_s1] <= 1'b0;
			end
			if (push) begin
				count_q[lk_s1] <= count_s1 + 1'b1;
			end
			if (pop) begin
				count_q[lk_s1] <= count_s1 - 1'b1;
				head_q[lk_s1]  <= head_next;
			end
		end
	end

	// A request is decided exactly once, and never overlaps a new acceptance.
	a_single_decide: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !accept)
		else $error("request accepted while the previous one is being decided");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> count_s1 <= CNT_W'(QUEUE_DEPTH))
		else $error("waiter count exceeds the queue depth");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(push && pop) && !(lock_set && lock_clr))
		else $error("conflicting updates in one decision");

endmodule

// File: design/ltwq_emit.sv
// Result sequencer: holds the decided results of one request and presents them
// one per cycle on registered outputs. Depends on ltwq_pkg.
module ltwq_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  ltwq_pkg::plan_t plan,
	output logic            hold,
	output logic            strobe,
	output logic [2:0]      kind,
	output logic [7:0]      target_client,
	output logic [3:0]      lock_ref,
	output logic            last
);
	import ltwq_pkg::*;

	plan_t            res_q;
	logic [IDX_W-1:0] idx_q;
	logic [RES_W-1:0] rem_q;

	logic    strobe_q;
	kind_t   kind_q;
	client_t target_q;
	lock_t   lock_q;
	logic    last_q;

	// Hold off new requests until at most the final result is left to send.
	assign hold = rem_q > RES_W'(1);

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= rem_q != '0;
			if (plan.valid) begin
				idx_q <= '0;
				rem_q <= plan.num;
			end else if (rem_q != '0) begin
				idx_q <= idx_q + 1'b1;
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	// Result buffer and output payload.
	always_ff @(posedge clk) begin
		if (plan.valid) begin
			res_q <= plan;
		end
		if (rem_q != '0) begin
			kind_q   <= res_q.kind[idx_q];
			target_q <= res_q.who[idx_q];
			lock_q   <= res_q.lock;
			last_q   <= rem_q == RES_W'(1);
		end
	end

	assign strobe        = strobe_q;
	assign kind          = 3'(kind_q);
	assign target_client = 8'(target_q);
	assign lock_ref      = 4'(lock_q);
	assign last          = last_q;

	// A new decision only arrives once the previous results have all gone out.
	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid |-> rem_q == '0)
		else $error("decision loaded while results are still pending");

	// The results of one request leave on consecutive cycles.
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q)
		else $error("gap inside the results of one request");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= RES_W'(MAX_RES))
		else $error("result count out of range");

endmodule

// File: design/lock_table_with_waiter_queues_core.sv
// Top level of the lock table with per-lock waiter queues.
// Instantiates ltwq_table and ltwq_emit; depends on ltwq_pkg.
//
// Usage:
// A request (command, lock_index, client) is taken at a rising edge where start
// is high and busy is low. Command 0 acquires the lock, command 1 releases it.
// Each request produces one to three results on kind, target_client, lock_ref
// and last, each shown for exactly one cycle with strobe high; last marks the
// final result of the request. The receiver cannot stall, so results are never
// held back.
// Flow: the request is registered together with the addressed lock's state
// and the front waiter read from the waiter memory, decided in the next cycle,
// loaded into the result sequencer's buffer, and its first result is then
// registered onto the outputs, the rest following on consecutive cycles.
// Occupancy: a request holds the block from acceptance until its final result
// is being registered; the single result sequencer sets this, and the next
// request may be accepted while that result is being registered.
// Reset clears all lock flags, holders and queue pointers at once; waiter
// memory contents are only used after being written and need no clearing.
module lock_table_with_waiter_queues_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       command,
	input  logic [3:0] lock_index,
	input  logic [7:0] client,
	output logic       strobe,
	output logic [2:0] kind,
	output logic [7:0] target_client,
	output logic [3:0] lock_ref,
	output logic       last
);
	import ltwq_pkg::*;

	plan_t plan;
	logic  hold;
	logic  accept;

	// Busy while a request is being decided or more than its final result is still to send.
	assign busy   = plan.valid || hold;
	assign accept = start && !busy;

	ltwq_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.lock_index (lock_index),
		.client     (client),
		.plan       (plan)
	);

	ltwq_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.plan          (plan),
		.hold          (hold),
		.strobe        (strobe),
		.kind          (kind),
		.target_client (target_client),
		.lock_ref      (lock_ref),
		.last          (last)
	);

endmodule

// File: tb/lock_table_with_waiter_queues_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lock table with per-lock waiter queues.
// Drives acquire and release requests, predicts every result and checks them.
// Depends on ltwq_pkg and lock_table_with_waiter_queues_core.
module lock_table_with_waiter_queues_core_test;
	import ltwq_pkg::*;

	localparam int WATCHDOG_LIMIT = 200;
	localparam int MAX_GAP        = 20;
	localparam int ITEMS_PER_PASS = 100;

	// One result as the block should present it.
	typedef struct {
		kind_t   kind;
		client_t who;
		lock_t   lock;
		logic    last;
	} lock_result_t;

	// Tracks lock ownership and waiter queues, and holds the results still owed.
	class lock_outcome_tracker;
		bit                   locked [NUM_LOCKS];
		bit [CLIENT_BITS-1:0] holder [NUM_LOCKS];
		bit [CLIENT_BITS-1:0] waiters [NUM_LOCKS][QUEUE_DEPTH];
		int                   head [NUM_LOCKS];
		int                   count [NUM_LOCKS];
		lock_result_t         pending_results [$];
		int                   mismatches;

		task report(string msg);
			$display("[%0t] %s", $time, msg);
			mismatches++;
		endtask

		function void owe(kind_t k, client_t who, lock_t lk, logic fin);
			lock_result_t r;
			r.kind = k;
			r.who  = who;
			r.lock = lk;
			r.last = fin;
			pending_results.push_back(r);
		endfunction

		// Works out the results of one accepted request and updates the table.
		function void note_request(cmd_t c, lock_t lk, client_t who);
			int      slot;
			client_t front;
			if (c == CMD_ACQUIRE) begin
				if (!locked[lk]) begin
					locked[lk] = 1'b1;
					holder[lk] = who;
					owe(KIND_OK, who, lk, 1'b1);
				end else if (count[lk] >= QUEUE_DEPTH) begin
					owe(KIND_QUEUE_FULL, who, lk, 1'b1);
				end else begin
					slot = (head[lk] + count[lk]) % QUEUE_DEPTH;
					waiters[lk][slot] = who;
					count[lk]++;
					owe(KIND_REVOKE, holder[lk], lk, 1'b0);
					owe(KIND_RETRY_REPLY, who, lk, 1'b1);
				end
			end else begin
				// Any release frees the lock, whoever sends it.
				locked[lk] = 1'b0;
				if (count[lk] > 0) begin
					front = waiters[lk][head[lk]];
					head[lk] = (head[lk] + 1) % QUEUE_DEPTH;
					count[lk]--;
					owe(KIND_RETRY_MSG, front, lk, 1'b0);
					if (count[lk] > 0)
						owe(KIND_REVOKE, front, lk, 1'b0);
				end
				owe(KIND_OK, who, lk, 1'b1);
			end
		endfunction

		// Compares one observed result with the oldest one still owed.
		task check_result(logic [2:0] k, client_t who, lock_t lk, logic fin);
			lock_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result: kind %0d client %0d lock %0d last %0b",
					k, who, lk, fin));
				return;
			end
			want = pending_results.pop_front();
			if (k !== want.kind)
				report($sformatf("kind mismatch: got %0d, expected %0d", k, want.kind));
			if (who !== want.who)
				report($sformatf("target_client mismatch: got %0d, expected %0d",
					who, want.who));
			if (lk !== want.lock)
				report($sformatf("lock_ref mismatch: got %0d, expected %0d", lk, want.lock));
			if (fin !== want.last)
				report($sformatf("last mismatch: got %0b, expected %0b", fin, want.last));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       command;
	logic [3:0] lock_index;
	logic [7:0] client;
	logic       strobe;
	logic [2:0] kind;
	logic [7:0] target_client;
	logic [3:0] lock_ref;
	logic       last;

	lock_outcome_tracker tracker = new();
	int                  quiet_cycles = 0;

	lock_table_with_waiter_queues_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.lock_index   (lock_index),
		.client       (client),
		.strobe       (strobe),
		.kind         (kind),
		.target_client(target_client),
		.lock_ref     (lock_ref),
		.last         (last)
	);

	// Clock with an 8 ns period.
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Every strobed result is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && strobe)
			tracker.check_result(kind, target_client, lock_ref, last);
	end

	// The run is abandoned if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Presents one request and holds it until the block takes it.
	task automatic send_request(input cmd_t c, input lock_t lk, input client_t who);
		@(negedge clk);
		start      <= 1'b1;
		command    <= c;
		lock_index <= lk;
		client     <= who;
		do @(posedge clk); while (busy);
		tracker.note_request(c, lk, who);
	endtask

	// Leaves the request lines idle for a random number of cycles.
	task automatic sender_gap(input int pct);
		int n;
		n = 0;
		if ($urandom_range(99) < pct) begin
			@(negedge clk);
			start      <= 1'b0;
			command    <= 1'($urandom_range(1));
			lock_index <= 4'($urandom_range(15));
			client     <= 8'($urandom_range(255));
			while (n < MAX_GAP && $urandom_range(99) < pct) begin
				@(negedge clk);
				n++;
			end
		end
	endtask

	// Holds off new requests until every owed result has arrived.
	task automatic wait_for_results;
		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Random requests, mostly aimed at two busy locks so that queues fill up.
	task automatic random_pass(input int pct);
		lock_t   hot_a;
		lock_t   hot_b;
		lock_t   lk;
		cmd_t    c;
		client_t who;
		hot_a = LOCK_W'($urandom_range(15));
		hot_b = LOCK_W'($urandom_range(15));
		for (int i = 0; i < ITEMS_PER_PASS; i++) begin
			case ($urandom_range(3))
				0:       lk = LOCK_W'($urandom_range(15));
				1:       lk = hot_b;
				default: lk = hot_a;
			endcase
			if ($urandom_range(99) < 62)
				c = CMD_ACQUIRE;
			else
				c = CMD_RELEASE;
			who = CLIENT_BITS'($urandom_range(255));
			// Now and then the current holder asks again.
			if ($urandom_range(9) == 0)
				who = tracker.holder[lk];
			send_request(c, lk, who);
			sender_gap(pct);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		command    = 1'b0;
		lock_index = '0;
		client     = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: grant, queue up to full, release with and without waiters.
		send_request(CMD_ACQUIRE, 4'd0, 8'h00);
		send_request(CMD_ACQUIRE, 4'd0, 8'hFF);
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			send_request(CMD_ACQUIRE, 4'd0, client_t'(i));
			sender_gap(34);
		end
		send_request(CMD_ACQUIRE, 4'd0, 8'h80);
		send_request(CMD_RELEASE, 4'd0, 8'h00);
		// The lock is free again although clients still wait for it.
		send_request(CMD_ACQUIRE, 4'd0, 8'h33);
		send_request(CMD_ACQUIRE, 4'd0, 8'h44);
		send_request(CMD_ACQUIRE, 4'd0, 8'h45);
		// Release of a lock that nobody holds.
		send_request(CMD_RELEASE, 4'd15, 8'hAA);
		send_request(CMD_ACQUIRE, 4'd15, 8'h55);
		// The holder asks for its own lock again and is queued.
		send_request(CMD_ACQUIRE, 4'd15, 8'h55);
		// Release by a client that does not hold the lock.
		send_request(CMD_RELEASE, 4'd15, 8'h12);
		send_request(CMD_ACQUIRE, 4'd15, 8'h0F);
		send_request(CMD_RELEASE, 4'd0, 8'h7E);
		wait_for_results();

		// Random part in three passes of differing sender idling.
		random_pass(34);
		wait_for_results();
		random_pass(69);
		wait_for_results();
		random_pass(0);
		wait_for_results();

		// Allow any stray result to show up before judging the run.
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
